// File: hdl/pds_pkg.sv
package pds_pkg;

  // field widths
  localparam int unsigned SAMPLE_BITS  = 12;
  localparam int unsigned SETPOINT_W   = 12;
  localparam int unsigned GAIN_W       = 32;
  localparam int unsigned DUTY_W       = 11;
  localparam int unsigned BAND_W       = 10;
  localparam int unsigned LIMIT_W      = 16;
  localparam int unsigned HOLD_W       = 8;
  localparam int unsigned DRIVE_W      = 32;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned FRAC_BITS    = 24;

  // integral never exceeds limit plus one sample
  localparam int unsigned INT_W        = 17;

  // datapath widths
  localparam int unsigned ERR_W  =
    ((SAMPLE_BITS > SETPOINT_W) ? SAMPLE_BITS : SETPOINT_W) + 1;
  localparam int unsigned PE_W   = GAIN_W + ERR_W;
  localparam int unsigned PI_W   = GAIN_W + INT_W + 1;
  localparam int unsigned SUM_W  = PI_W + 2;
  localparam int unsigned DRV_W  = SUM_W - FRAC_BITS;
  localparam int unsigned DSUM_W = DUTY_W + 2;

  // constants
  localparam logic [DUTY_W-1:0] DUTY_MAX     = '1;
  localparam logic [HOLD_W-1:0] KICK_HOLD_MS = HOLD_W'(100);
  localparam logic [HOLD_W-1:0] BASE_HOLD_MS = HOLD_W'(200);

  // register reset values
  localparam logic [SETPOINT_W-1:0] SETPOINT_RST   = SETPOINT_W'(20);
  localparam logic [GAIN_W-1:0]     GAIN_P_RST     = GAIN_W'(5033165);
  localparam logic [GAIN_W-1:0]     GAIN_I_RST     = GAIN_W'(5);
  localparam logic [GAIN_W-1:0]     GAIN_D_RST     = GAIN_W'(0);
  localparam logic [DUTY_W-1:0]     BASE_LEFT_RST  = DUTY_W'(800);
  localparam logic [DUTY_W-1:0]     BASE_RIGHT_RST = DUTY_W'(700);
  localparam logic [BAND_W-1:0]     BAND_RST       = BAND_W'(30);
  localparam logic [LIMIT_W-1:0]    LIMIT_RST      = LIMIT_W'(100);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT   = 3'd0,
    REG_GAIN_P     = 3'd1,
    REG_GAIN_I     = 3'd2,
    REG_GAIN_D     = 3'd3,
    REG_BASE_LEFT  = 3'd4,
    REG_BASE_RIGHT = 3'd5,
    REG_BAND       = 3'd6,
    REG_INT_LIMIT  = 3'd7
  } cfg_reg_e;

endpackage

// File: hdl/pds_if.sv
interface pds_sample_if import pds_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface pds_result_if import pds_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [DUTY_W-1:0]         left_duty;
  logic [DUTY_W-1:0]         right_duty;
  logic [HOLD_W-1:0]         hold_ms;
  logic signed [DRIVE_W-1:0] drive;
  logic                      last;

  modport source (output valid, output left_duty, output right_duty, output hold_ms,
                  output drive, output last, input ready);
  modport sink   (input valid, input left_duty, input right_duty, input hold_ms,
                  input drive, input last, output ready);
endinterface

// File: hdl/pid_distance_steering.sv
// The first result of a request passes through the stage registers and then the output register.
// Throughput: one request per cycle while results are taken and each gives one result; a request
// outside the steering band gives two results and holds the output register until both are taken.
// The five pipeline stages stall together from the output register backwards.
// Reset: registers return to their defaults, integral and previous sample clear, pipeline empties.
module pid_distance_steering import pds_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pds_sample_if.sink            samp_i,
  pds_result_if.source          res_o
);

  // configuration registers
  logic [SETPOINT_W-1:0]    setpoint_q;
  logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [DUTY_W-1:0]        base_left_q, base_right_q;
  logic [BAND_W-1:0]        band_q;
  logic [LIMIT_W-1:0]       limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q   <= SETPOINT_RST;
      gain_p_q     <= GAIN_P_RST;
      gain_i_q     <= GAIN_I_RST;
      gain_d_q     <= GAIN_D_RST;
      base_left_q  <= BASE_LEFT_RST;
      base_right_q <= BASE_RIGHT_RST;
      band_q       <= BAND_RST;
      limit_q      <= LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SETPOINT:   setpoint_q   <= cfg_data_i[SETPOINT_W-1:0];
        REG_GAIN_P:     gain_p_q     <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_I:     gain_i_q     <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_D:     gain_d_q     <= cfg_data_i[GAIN_W-1:0];
        REG_BASE_LEFT:  base_left_q  <= cfg_data_i[DUTY_W-1:0];
        REG_BASE_RIGHT: base_right_q <= cfg_data_i[DUTY_W-1:0];
        REG_BAND:       band_q       <= cfg_data_i[BAND_W-1:0];
        REG_INT_LIMIT:  limit_q      <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and stall chain
  logic v1_q, v2_q, v3_q, v4_q, out_v_q;
  logic en1, en2, en3, en4, en_out;
  logic out_hs, in_hs;
  logic out_last_q;

  assign out_hs = out_v_q && res_o.ready;
  assign en_out = !out_v_q || (out_hs && out_last_q);
  assign en4    = !v4_q || en_out;
  assign en3    = !v3_q || en4;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;
  assign samp_i.ready = en1;
  assign in_hs  = samp_i.valid && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= samp_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // loop state: previous sample and integral, updated on every accepted request
  logic [SAMPLE_BITS-1:0] prev_q;
  logic                   have_prev_q;
  logic [INT_W-1:0]       integral_q, integral_sum, integral_d;

  assign integral_sum = integral_q + INT_W'(samp_i.sample);
  assign integral_d   = (integral_sum > INT_W'(limit_q)) ? '0 : integral_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      integral_q  <= '0;
    end else if (in_hs) begin
      prev_q      <= samp_i.sample;
      have_prev_q <= 1'b1;
      integral_q  <= integral_d;
    end
  end

  // stage 1: error, derivative and integral operand
  logic signed [ERR_W-1:0] err_d, der_d, err_q, der_q;
  logic [INT_W-1:0]        integ_q;

  assign err_d = $signed(ERR_W'(samp_i.sample)) - $signed(ERR_W'(setpoint_q));
  assign der_d = have_prev_q ? ($signed(ERR_W'(samp_i.sample)) - $signed(ERR_W'(prev_q)))
                             : '0;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      err_q   <= err_d;
      der_q   <= der_d;
      integ_q <= integral_q;
    end
  end

  // stage 2: the three gain products
  logic signed [PE_W-1:0]  pp_d, pd_d, pp_q, pd_q;
  logic signed [PI_W-1:0]  pi_d, pi_q;
  logic signed [INT_W:0]   integ_s;

  assign integ_s = $signed({1'b0, integ_q});
  assign pp_d    = err_q * gain_p_q;
  assign pd_d    = der_q * gain_d_q;
  assign pi_d    = integ_s * gain_i_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      pp_q <= pp_d;
      pi_q <= pi_d;
      pd_q <= pd_d;
    end
  end

  // stage 3: Q24 sum
  logic signed [SUM_W-1:0] sum_d, sum_q;

  assign sum_d = SUM_W'(pp_q) + SUM_W'(pi_q) + SUM_W'(pd_q);

  always_ff @(posedge clk_i) begin
    if (en3) sum_q <= sum_d;
  end

  // stage 4: drop the fraction, truncating toward zero
  logic [SUM_W-1:0]        sum_bias;
  logic signed [SUM_W-1:0] sum_adj;
  logic signed [DRV_W-1:0] drv_q;

  assign sum_bias = sum_q[SUM_W-1] ? {{DRV_W{1'b0}}, {FRAC_BITS{1'b1}}} : '0;
  assign sum_adj  = sum_q + $signed(sum_bias);

  always_ff @(posedge clk_i) begin
    if (en4) drv_q <= sum_adj[SUM_W-1:FRAC_BITS];
  end

  // band decision and duty forming
  function automatic logic [DUTY_W-1:0] sat_duty(input logic signed [DSUM_W-1:0] v);
    logic [DUTY_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(DSUM_W'(DUTY_MAX))) begin
      r = DUTY_MAX;
    end else begin
      r = v[DUTY_W-1:0];
    end
    return r;
  endfunction

  logic                     drv_neg, steer, kick;
  logic [DRV_W-1:0]         drv_mag;
  logic signed [DUTY_W:0]   drv_lo;
  logic signed [DSUM_W-1:0] left_sum, right_sum, kick_sum;
  logic [DUTY_W-1:0]        left_d, right_d;

  assign drv_neg   = drv_q[DRV_W-1];
  assign drv_mag   = drv_neg ? DRV_W'(-drv_q) : DRV_W'(drv_q);
  assign steer     = drv_mag < DRV_W'(band_q);
  assign kick      = !steer;
  // in the steering band the drive is below the band, so its low bits carry it
  assign drv_lo    = drv_q[DUTY_W:0];
  assign left_sum  = $signed(DSUM_W'(base_left_q)) + DSUM_W'(drv_lo);
  assign right_sum = $signed(DSUM_W'(base_right_q)) + DSUM_W'(drv_lo);
  assign kick_sum  = $signed(DSUM_W'(base_right_q) + DSUM_W'(band_q));

  always_comb begin
    left_d  = base_left_q;
    right_d = base_right_q;
    priority if (kick) begin
      right_d = sat_duty(kick_sum);
    end else if (drv_neg) begin
      left_d  = sat_duty(left_sum);
    end else begin
      right_d = sat_duty(right_sum);
    end
  end

  // output register: kick result then base result, or one steering result
  logic [DUTY_W-1:0]         out_left_q, out_right_q;
  logic [HOLD_W-1:0]         out_hold_q;
  logic signed [DRIVE_W-1:0] out_drive_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
    end else if (en_out) begin
      out_v_q    <= v4_q;
      out_last_q <= !kick;
    end else if (out_hs) begin
      out_last_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      out_left_q  <= left_d;
      out_right_q <= right_d;
      out_hold_q  <= kick ? KICK_HOLD_MS : '0;
      out_drive_q <= DRIVE_W'(drv_q);
    end else if (out_hs) begin
      out_left_q  <= base_left_q;
      out_right_q <= base_right_q;
      out_hold_q  <= BASE_HOLD_MS;
    end
  end

  assign res_o.valid      = out_v_q;
  assign res_o.left_duty  = out_left_q;
  assign res_o.right_duty = out_right_q;
  assign res_o.hold_ms    = out_hold_q;
  assign res_o.drive      = out_drive_q;
  assign res_o.last       = out_last_q;

  // checks
  a_pair_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_last_q |=> out_v_q)
    else $error("kick result left without its base result");

  a_base_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs && !out_last_q |=> out_last_q && (out_hold_q == BASE_HOLD_MS))
    else $error("base result does not follow kick result");

  a_kick_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_last_q |-> out_hold_q == KICK_HOLD_MS)
    else $error("non-final result without kick hold");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_hs |=> v1_q)
    else $error("accepted request lost at first stage");

endmodule
